// ----- hdl/wcs_pkg.sv -----
package wcs_pkg;

  localparam int unsigned VAL_W = 51;
  localparam int unsigned OWN_W = 8;
  // Wide enough for the sum of a full table of maximal coins.
  localparam int unsigned SUM_W = 57;
  localparam int unsigned KEY_W = VAL_W + OWN_W;
  localparam int unsigned DATA_W = 112;

  localparam int unsigned DEF_COIN_SLOTS = 64;
  localparam int unsigned DEF_ADDRESS_COUNT = 256;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef enum logic [1:0] {
    STAT_STORED = 2'd0,
    STAT_PICKED = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BAD    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_STORE,
    S_SCAN,
    S_DECIDE,
    S_MARK,
    S_GSCAN,
    S_GSEL,
    S_GPICK,
    S_GFIN,
    S_SWAP,
    S_ESCAN,
    S_EWAIT,
    S_EREM,
    S_ENEXT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              picked;
    logic [VAL_W-1:0]  value;
    logic [OWN_W-1:0]  owner;
  } slot_t;

endpackage

// ----- hdl/wcs_cell.sv -----
module wcs_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  wcs_pkg::slot_t d_i,
  output wcs_pkg::slot_t q_o
);
  import wcs_pkg::*;

  logic             valid_q;
  logic             picked_q;
  logic [VAL_W-1:0] value_q;
  logic [OWN_W-1:0] owner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      picked_q <= 1'b0;
    end else if (shift_i) begin
      valid_q  <= d_i.valid;
      picked_q <= d_i.picked;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      value_q <= d_i.value;
      owner_q <= d_i.owner;
    end
  end

  assign q_o = '{valid: valid_q, picked: picked_q, value: value_q, owner: owner_q};

endmodule

// ----- hdl/wcs_ctrl.sv -----
module wcs_ctrl #(
  parameter int unsigned COIN_SLOTS    = wcs_pkg::DEF_COIN_SLOTS,
  parameter int unsigned ADDRESS_COUNT = wcs_pkg::DEF_ADDRESS_COUNT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [wcs_pkg::VAL_W-1:0]  coin_value_i,
  input  logic [wcs_pkg::OWN_W-1:0]  owner_index_i,
  input  logic [wcs_pkg::VAL_W-1:0]  amount_i,
  input  wcs_pkg::slot_t             head_i,
  output wcs_pkg::slot_t             wb_o,
  output logic                       shift_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output wcs_pkg::status_e           status_o,
  output logic [wcs_pkg::OWN_W-1:0]  picked_owner_o,
  output logic [wcs_pkg::VAL_W-1:0]  picked_value_o,
  output logic [wcs_pkg::VAL_W-1:0]  total_sum_o,
  output logic                       last_o
);
  import wcs_pkg::*;

  localparam int unsigned IW = $clog2(COIN_SLOTS);
  localparam int unsigned CW = $clog2(COIN_SLOTS + 1);

  state_e state_q, state_d;

  logic [IW-1:0]    cnt_q;
  logic             done_q;
  logic [VAL_W-1:0] amt_q, val_q;
  logic [OWN_W-1:0] own_q;
  logic [SUM_W-1:0] bal_q, lsum_q;
  logic [CW-1:0]    nlow_q, npick_q;
  logic             ex_f_q, lg_f_q, ge_f_q, mx_f_q, em_f_q, bnd_inf_q, mode_low_q;
  logic [OWN_W-1:0] ex_own_q;
  logic [KEY_W-1:0] lg_key_q, ge_key_q, mx_key_q, pk_key_q, bnd_q, em_key_q;
  logic [VAL_W:0]   gsum_q;
  logic [VAL_W-1:0] total_q;
  status_e          stat_q;

  logic             o_valid_q, o_last_q;
  status_e          o_st_q;
  logic [OWN_W-1:0] o_own_q;
  logic [VAL_W-1:0] o_val_q, o_sum_q;

  logic             accept, pass_end, own_ok;
  logic [KEY_W-1:0] e_key, e_okey;
  logic             lt_amt, eq_amt, cand;
  logic [VAL_W-1:0] rem;
  logic [VAL_W:0]   gsum_add;
  logic             hit_pk, hit_lg, hit_em;
  logic             bad_amt;
  logic [SUM_W-1:0] amt_ext;

  assign accept   = in_valid_i && in_ready_o;
  assign pass_end = (cnt_q == IW'(COIN_SLOTS - 1));
  assign own_ok   = ({1'b0, own_q} < 9'(ADDRESS_COUNT));
  assign e_key    = {head_i.value, head_i.owner};
  assign e_okey   = {head_i.owner, head_i.value};
  assign lt_amt   = head_i.value < amt_q;
  assign eq_amt   = head_i.value == amt_q;
  assign rem      = amt_q - gsum_q[VAL_W-1:0];
  assign cand     = head_i.valid && !head_i.picked && lt_amt && (bnd_inf_q || e_key <= bnd_q);
  assign gsum_add = gsum_q + {1'b0, pk_key_q[KEY_W-1:OWN_W]};
  assign hit_pk   = head_i.valid && !head_i.picked && (e_key == pk_key_q) && !done_q;
  assign hit_lg   = head_i.valid && (e_key == lg_key_q) && !done_q;
  assign hit_em   = head_i.valid && head_i.picked && (e_okey == em_key_q) && !done_q;
  assign amt_ext  = {{(SUM_W-VAL_W){1'b0}}, amt_q};
  assign bad_amt  = (amt_q == '0) || (bal_q < amt_ext);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = (op_i == OP_SELECT) ? S_SCAN : S_MOD;
      S_MOD:    if (own_ok) state_d = S_STORE;
      S_STORE:  if (pass_end) state_d = S_OUT;
      S_SCAN:   if (pass_end) state_d = S_DECIDE;
      S_DECIDE: begin
        priority if (bad_amt) state_d = S_OUT;
        else if (ex_f_q) state_d = S_MARK;
        else if (lsum_q == amt_ext) state_d = S_MARK;
        else if (lsum_q < amt_ext) state_d = lg_f_q ? S_MARK : S_OUT;
        else state_d = S_GSCAN;
      end
      S_MARK:   if (pass_end) state_d = S_ESCAN;
      S_GSCAN:  if (pass_end) state_d = S_GSEL;
      S_GSEL:   state_d = mx_f_q ? S_GPICK : S_GFIN;
      S_GPICK:  if (pass_end) state_d = (gsum_add >= {1'b0, amt_q}) ? S_GFIN : S_GSCAN;
      S_GFIN:   state_d = (lg_f_q && gsum_q > {1'b0, lg_key_q[KEY_W-1:OWN_W]}) ? S_SWAP : S_ESCAN;
      S_SWAP:   if (pass_end) state_d = S_ESCAN;
      S_ESCAN:  if (pass_end) state_d = S_EWAIT;
      S_EWAIT:  if (!o_valid_q) state_d = S_EREM;
      S_EREM:   if (pass_end) state_d = S_ENEXT;
      S_ENEXT:  state_d = (npick_q == '0) ? S_IDLE : S_ESCAN;
      S_OUT:    if (!o_valid_q) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_STORE, S_SCAN, S_MARK, S_GSCAN, S_GPICK, S_SWAP, S_ESCAN, S_EREM: shift_o = 1'b1;
      default: shift_o = 1'b0;
    endcase
  end

  // Write-back of the entry leaving the head of the ring.
  always_comb begin
    wb_o = head_i;
    unique case (state_q)
      S_STORE: begin
        if (!head_i.valid && !done_q) begin
          wb_o.valid = 1'b1;
          wb_o.value = val_q;
          wb_o.owner = own_q;
        end
      end
      S_MARK: begin
        if (mode_low_q) begin
          if (head_i.valid && lt_amt) wb_o.picked = 1'b1;
        end else if (hit_pk) begin
          wb_o.picked = 1'b1;
        end
      end
      S_GPICK: if (hit_pk) wb_o.picked = 1'b1;
      S_SWAP:  if (head_i.valid) wb_o.picked = hit_lg;
      S_EREM: begin
        if (hit_em) begin
          wb_o.valid  = 1'b0;
          wb_o.picked = 1'b0;
        end
      end
      default: wb_o = head_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift_o) cnt_q <= pass_end ? '0 : cnt_q + 1'b1;
      if (shift_o && pass_end) begin
        done_q <= 1'b0;
      end else if (shift_o && (state_q == S_STORE) && !head_i.valid) begin
        done_q <= 1'b1;
      end else if ((state_q == S_MARK && !mode_low_q && hit_pk) ||
                   (state_q == S_GPICK && hit_pk) ||
                   (state_q == S_SWAP && hit_lg) ||
                   (state_q == S_EREM && hit_em)) begin
        done_q <= 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        o_valid_q <= 1'b0;
      end else if ((state_q == S_OUT && !o_valid_q) || (state_q == S_EREM && hit_em)) begin
        o_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        amt_q     <= amount_i;
        val_q     <= coin_value_i;
        own_q     <= owner_index_i;
        bal_q     <= '0;
        lsum_q    <= '0;
        nlow_q    <= '0;
        ex_f_q    <= 1'b0;
        lg_f_q    <= 1'b0;
        ge_f_q    <= 1'b0;
        mx_f_q    <= 1'b0;
        em_f_q    <= 1'b0;
        bnd_inf_q <= 1'b1;
        gsum_q    <= '0;
      end
      S_MOD: if (!own_ok) own_q <= own_q - OWN_W'(ADDRESS_COUNT);
      S_STORE: if (pass_end) stat_q <= (done_q || !head_i.valid) ? STAT_STORED : STAT_FULL;
      S_SCAN: begin
        if (head_i.valid) begin
          bal_q <= bal_q + SUM_W'(head_i.value);
          if (eq_amt) begin
            if (!ex_f_q || head_i.owner < ex_own_q) ex_own_q <= head_i.owner;
            ex_f_q <= 1'b1;
          end else if (lt_amt) begin
            lsum_q <= lsum_q + SUM_W'(head_i.value);
            nlow_q <= nlow_q + 1'b1;
          end else begin
            if (!lg_f_q || e_key < lg_key_q) lg_key_q <= e_key;
            lg_f_q <= 1'b1;
          end
        end
      end
      S_DECIDE: begin
        stat_q     <= STAT_BAD;
        mode_low_q <= !bad_amt && !ex_f_q && (lsum_q == amt_ext);
        priority if (bad_amt) begin
          npick_q <= CW'(1);
        end else if (ex_f_q) begin
          npick_q  <= CW'(1);
          pk_key_q <= {amt_q, ex_own_q};
          total_q  <= amt_q;
        end else if (lsum_q == amt_ext) begin
          npick_q <= nlow_q;
          total_q <= amt_q;
        end else if (lsum_q < amt_ext) begin
          npick_q  <= CW'(1);
          pk_key_q <= lg_key_q;
          total_q  <= lg_key_q[KEY_W-1:OWN_W];
        end else begin
          npick_q <= '0;
        end
      end
      S_GSCAN: begin
        if (cand) begin
          if (head_i.value >= rem && (!ge_f_q || e_key < ge_key_q)) begin
            ge_key_q <= e_key;
            ge_f_q   <= 1'b1;
          end
          if (!mx_f_q || e_key > mx_key_q) begin
            mx_key_q <= e_key;
            mx_f_q   <= 1'b1;
          end
        end
      end
      S_GSEL: begin
        // Smallest candidate that covers the rest, else the largest one.
        pk_key_q <= ge_f_q ? ge_key_q : mx_key_q;
        ge_f_q   <= 1'b0;
        mx_f_q   <= 1'b0;
      end
      S_GPICK: begin
        if (pass_end) begin
          gsum_q    <= gsum_add;
          bnd_q     <= pk_key_q;
          bnd_inf_q <= 1'b0;
          npick_q   <= npick_q + 1'b1;
        end
      end
      S_GFIN: begin
        if (lg_f_q && gsum_q > {1'b0, lg_key_q[KEY_W-1:OWN_W]}) begin
          total_q <= lg_key_q[KEY_W-1:OWN_W];
          npick_q <= CW'(1);
        end else begin
          total_q <= gsum_q[VAL_W] ? {VAL_W{1'b1}} : gsum_q[VAL_W-1:0];
        end
      end
      S_ESCAN: begin
        if (head_i.valid && head_i.picked && (!em_f_q || e_okey < em_key_q)) begin
          em_key_q <= e_okey;
          em_f_q   <= 1'b1;
        end
      end
      S_EREM: begin
        if (hit_em) begin
          o_st_q  <= STAT_PICKED;
          o_own_q <= head_i.owner;
          o_val_q <= head_i.value;
          o_sum_q <= total_q;
          o_last_q <= (npick_q == CW'(1));
          npick_q <= npick_q - 1'b1;
        end
      end
      S_ENEXT: em_f_q <= 1'b0;
      S_OUT: begin
        if (!o_valid_q) begin
          o_st_q   <= stat_q;
          o_own_q  <= (stat_q == STAT_STORED) ? own_q : '0;
          o_val_q  <= (stat_q == STAT_STORED) ? val_q : '0;
          o_sum_q  <= '0;
          o_last_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = o_valid_q;
  assign status_o       = o_st_q;
  assign picked_owner_o = o_own_q;
  assign picked_value_o = o_val_q;
  assign total_sum_o    = o_sum_q;
  assign last_o         = o_last_q;

endmodule

// ----- hdl/wallet_coin_selector.sv -----
// Coin table kept as a ring of COIN_SLOTS cells that rotates past one head unit; every
// look at the table is a full turn of the ring. A store fills a free cell in one turn,
// after ADDRESS_COUNT is subtracted from an out-of-range owner until it is in range.
// A select totals the balance and classifies coins in a scan turn, then marks an exact
// or covering pick, or runs a greedy descent of a scan and a pick turn per coin and may
// swap in the larger coin; each coin is then emitted by a scan turn and a removal turn.
// A new request is taken only when the previous one has finished; its results are held
// in an output register until taken. Emitted coins come in ascending owner, then value.
module wallet_coin_selector #(
  parameter int unsigned COIN_SLOTS    = wcs_pkg::DEF_COIN_SLOTS,
  parameter int unsigned ADDRESS_COUNT = wcs_pkg::DEF_ADDRESS_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // coin_value[50:0], owner_index[58:51], amount[109:59], zero fill
  input  logic [wcs_pkg::DATA_W-1:0]  s_axis_tdata_i,
  // op
  input  logic                        s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // picked_owner[7:0], picked_value[58:8], total_sum[109:59], zero fill
  output logic [wcs_pkg::DATA_W-1:0]  m_axis_tdata_o,
  // status
  output logic [1:0]                  m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);
  import wcs_pkg::*;

  slot_t            ring [COIN_SLOTS];
  slot_t            wb;
  logic             shift;
  status_e          status;
  logic [OWN_W-1:0] p_own;
  logic [VAL_W-1:0] p_val, p_sum;

  for (genvar i = 0; i < COIN_SLOTS; i++) begin : g_cell
    wcs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     ((i == COIN_SLOTS - 1) ? wb : ring[(i + 1) % COIN_SLOTS]),
      .q_o     (ring[i])
    );
  end

  wcs_ctrl #(
    .COIN_SLOTS    (COIN_SLOTS),
    .ADDRESS_COUNT (ADDRESS_COUNT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .op_i           (s_axis_tuser_i),
    .coin_value_i   (s_axis_tdata_i[VAL_W-1:0]),
    .owner_index_i  (s_axis_tdata_i[VAL_W+OWN_W-1:VAL_W]),
    .amount_i       (s_axis_tdata_i[2*VAL_W+OWN_W-1:VAL_W+OWN_W]),
    .head_i         (ring[0]),
    .wb_o           (wb),
    .shift_o        (shift),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .status_o       (status),
    .picked_owner_o (p_own),
    .picked_value_o (p_val),
    .total_sum_o    (p_sum),
    .last_o         (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = status;
  assign m_axis_tdata_o = {{(DATA_W-2*VAL_W-OWN_W){1'b0}}, p_sum, p_val, p_own};

endmodule

// ----- hdl/wcs_checker.sv -----
module wcs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [wcs_pkg::DATA_W-1:0]  m_axis_tdata_o,
  input logic [1:0]                  m_axis_tuser_o,
  input logic                        m_axis_tlast_o
);
  import wcs_pkg::*;

  logic picked, failed;

  assign picked = (m_axis_tuser_o == STAT_PICKED);
  assign failed = (m_axis_tuser_o == STAT_FULL) || (m_axis_tuser_o == STAT_BAD);

  // Only a selection spreads over several results.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !picked |-> m_axis_tlast_o)
    else $error("non-selection result without tlast");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && failed |-> (m_axis_tdata_o == '0))
    else $error("failed request carries data");

  a_total_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && picked |->
      (m_axis_tdata_o[2*VAL_W+OWN_W-1:VAL_W+OWN_W] >= m_axis_tdata_o[VAL_W+OWN_W-1:OWN_W]))
    else $error("selection total below a picked coin");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

endmodule

bind wallet_coin_selector wcs_checker u_wcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ----- dv/tb.sv -----
module tb;
  import wcs_pkg::*;

  localparam int unsigned SLOTS = DEF_COIN_SLOTS;
  localparam logic [VAL_W-1:0] VMAX = {VAL_W{1'b1}};
  localparam int unsigned STALL_LIMIT = 200000;

  typedef struct {
    status_e          st;
    logic [OWN_W-1:0] own;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] sum;
    logic             last;
  } coin_res_t;

  typedef struct {
    logic             op;
    logic [VAL_W-1:0] val;
    logic [OWN_W-1:0] own;
    logic [VAL_W-1:0] amt;
    bit               typed;
    coin_res_t        res;
  } coin_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [DATA_W-1:0] s_data = '0;
  logic s_user = OP_STORE;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [DATA_W-1:0] m_data;
  logic [1:0] m_user;
  logic m_last;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  wallet_coin_selector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  // Shadow copy of the coin table.
  bit               tbl_valid [SLOTS];
  logic [VAL_W-1:0] tbl_value [SLOTS];
  logic [OWN_W-1:0] tbl_owner [SLOTS];

  coin_res_t pending_q[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit idle_on = 1'b1;

  function automatic bit precedes(int a, int b, bit owner_first);
    longint unsigned ka1, kb1, ka2, kb2;
    ka1 = owner_first ? tbl_owner[a] : tbl_value[a];
    kb1 = owner_first ? tbl_owner[b] : tbl_value[b];
    ka2 = owner_first ? tbl_value[a] : tbl_owner[a];
    kb2 = owner_first ? tbl_value[b] : tbl_owner[b];
    if (ka1 != kb1) return ka1 < kb1;
    if (ka2 != kb2) return ka2 < kb2;
    return a < b;
  endfunction

  function automatic void sort_slots(ref int lst[$], input bit owner_first);
    int x, j;
    for (int i = 1; i < lst.size(); i++) begin
      x = lst[i];
      j = i - 1;
      while (j >= 0 && precedes(x, lst[j], owner_first)) begin
        lst[j + 1] = lst[j];
        j--;
      end
      lst[j + 1] = x;
    end
  endfunction

  function automatic coin_res_t mk(status_e st, logic [OWN_W-1:0] own,
                                   logic [VAL_W-1:0] val, logic [VAL_W-1:0] sum);
    coin_res_t r;
    r.st = st; r.own = own; r.val = val; r.sum = sum; r.last = 1'b1;
    return r;
  endfunction

  function automatic longint unsigned balance();
    longint unsigned b = 0;
    for (int s = 0; s < SLOTS; s++) if (tbl_valid[s]) b += tbl_value[s];
    return b;
  endfunction

  // Applies one request to the shadow table and returns the results it yields.
  function automatic void coin_select_predict(coin_req_t rq, ref coin_res_t res[$]);
    int exact, big, pos;
    int lower[$];
    int chosen[$];
    bit picked [SLOTS];
    longint unsigned lower_sum, sum, total;
    coin_res_t r;
    res.delete();
    if (rq.op == OP_STORE) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (!tbl_valid[s]) begin
          tbl_valid[s] = 1'b1;
          tbl_value[s] = rq.val;
          tbl_owner[s] = OWN_W'(rq.own % DEF_ADDRESS_COUNT);
          res = {res, mk(STAT_STORED, tbl_owner[s], rq.val, '0)};
          return;
        end
      end
      res = {res, mk(STAT_FULL, '0, '0, '0)};
      return;
    end
    if (rq.amt == 0 || balance() < rq.amt) begin
      res = {res, mk(STAT_BAD, '0, '0, '0)};
      return;
    end
    exact = -1; big = -1; lower_sum = 0;
    for (int s = 0; s < SLOTS; s++) begin
      picked[s] = 1'b0;
      if (!tbl_valid[s]) continue;
      if (tbl_value[s] == rq.amt) begin
        if (exact < 0 || precedes(s, exact, 1'b0)) exact = s;
      end else if (tbl_value[s] < rq.amt) begin
        lower = {lower, s};
        lower_sum += tbl_value[s];
      end else if (big < 0 || precedes(s, big, 1'b0)) begin
        big = s;
      end
    end
    if (exact >= 0) begin
      picked[exact] = 1'b1;
    end else if (lower_sum == rq.amt) begin
      foreach (lower[k]) picked[lower[k]] = 1'b1;
    end else if (lower_sum < rq.amt) begin
      if (big < 0) begin
        res = {res, mk(STAT_BAD, '0, '0, '0)};
        return;
      end
      picked[big] = 1'b1;
    end else begin
      // Greedy descent: take the smallest coin that still covers the rest, else the largest.
      sort_slots(lower, 1'b0);
      sum = 0;
      pos = lower.size() - 1;
      while (sum < rq.amt && pos >= 0) begin
        while (pos > 0 && tbl_value[lower[pos - 1]] >= rq.amt - sum) pos--;
        sum += tbl_value[lower[pos]];
        picked[lower[pos]] = 1'b1;
        pos--;
      end
      if (big >= 0 && sum > tbl_value[big]) begin
        foreach (lower[k]) picked[lower[k]] = 1'b0;
        picked[big] = 1'b1;
      end
    end
    total = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (picked[s]) begin
        chosen = {chosen, s};
        total += tbl_value[s];
      end
    end
    if (total > VMAX) total = VMAX;
    sort_slots(chosen, 1'b1);
    foreach (chosen[k]) begin
      r = mk(STAT_PICKED, tbl_owner[chosen[k]], tbl_value[chosen[k]], total[VAL_W-1:0]);
      r.last = (k == chosen.size() - 1);
      res = {res, r};
      tbl_valid[chosen[k]] = 1'b0;
    end
  endfunction

  task automatic send_request(coin_req_t rq);
    coin_res_t res[$];
    while (idle_on && $urandom_range(99) < 13) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= rq.op;
    s_data  <= {{(DATA_W - 2*VAL_W - OWN_W){1'b0}}, rq.amt, rq.own, rq.val};
    do @(posedge clk_i); while (!s_ready);
    coin_select_predict(rq, res);
    if (rq.typed) pending_q = {pending_q, rq.res};
    else pending_q = {pending_q, res};
  endtask

  // Result side: random back-pressure and the comparison against the oldest expectation.
  always @(posedge clk_i) begin
    coin_res_t want;
    logic [OWN_W-1:0] got_own;
    logic [VAL_W-1:0] got_val, got_sum;
    got_own = m_data[OWN_W-1:0];
    got_val = m_data[OWN_W +: VAL_W];
    got_sum = m_data[OWN_W+VAL_W +: VAL_W];
    if (rst_ni) begin
      m_ready <= !(idle_on && $urandom_range(99) < 13);
      if (m_valid && m_ready) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d owner %0d value %0d", m_user, got_own,
                     got_val);
        end else begin
          want = pending_q.pop_front();
          if (m_user !== want.st || got_own !== want.own || got_val !== want.val ||
              got_sum !== want.sum || m_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st %0d own %0d val %0d sum %0d last %0b, %s %0d %s %0d%s",
                       want.st, want.own, want.val, want.sum, want.last,
                       "got st", m_user, "own", got_own, "");
            if (mismatches <= 10)
              $display("  got val %0d sum %0d last %0b", got_val, got_sum, m_last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL wallet_coin_selector");
      $finish;
    end
  end

  function automatic coin_req_t row(logic op, logic [VAL_W-1:0] val, logic [OWN_W-1:0] own,
                                    logic [VAL_W-1:0] amt);
    coin_req_t rq;
    rq.op = op; rq.val = val; rq.own = own; rq.amt = amt; rq.typed = 1'b0;
    rq.res = mk(STAT_BAD, '0, '0, '0);
    return rq;
  endfunction

  function automatic coin_req_t typed_row(coin_req_t rq, coin_res_t res);
    rq.typed = 1'b1;
    rq.res = res;
    return rq;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(9))
      0, 1, 2, 3: return VAL_W'($urandom_range(60, 1));
      4, 5:       return w[VAL_W-1:0];
      6:          return VMAX;
      7:          return '0;
      8:          return {{(VAL_W-1){1'b0}}, 1'b1} << $urandom_range(VAL_W - 1);
      default:    return VAL_W'($urandom_range(5000, 1));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_amount();
    longint unsigned bal, acc;
    int s;
    logic [63:0] w;
    bal = balance();
    w = {$urandom(), $urandom()};
    if (bal == 0) return $urandom_range(3) == 0 ? '0 : w[VAL_W-1:0];
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5: begin
        do s = $urandom_range(SLOTS - 1); while (!tbl_valid[s]);
        return tbl_value[s] + VAL_W'($urandom_range(2)) - VAL_W'(1);
      end
      6, 7, 8, 9, 10: begin
        acc = 0;
        for (int k = 0; k < SLOTS; k++)
          if (tbl_valid[k] && $urandom_range(1)) acc += tbl_value[k];
        return VAL_W'(acc > VMAX ? VMAX : acc);
      end
      11, 12, 13, 14, 15: return VAL_W'((w % (bal > VMAX ? VMAX : bal)) + 1);
      16: return '0;
      17: return VAL_W'(bal >= VMAX ? VMAX : bal + 1);
      default: return VAL_W'($urandom_range(200, 1));
    endcase
  endfunction

  initial begin
    coin_req_t plan[$];
    coin_req_t rq;
    int n;
    plan = {plan, typed_row(row(OP_SELECT, '0, '0, 5), mk(STAT_BAD, '0, '0, '0))};
    plan = {plan, typed_row(row(OP_SELECT, VMAX, 8'hff, '0), mk(STAT_BAD, '0, '0, '0))};
    plan = {plan, typed_row(row(OP_STORE, VMAX, 8'hff, '0),
                            mk(STAT_STORED, 8'hff, VMAX, '0))};
    plan = {plan, typed_row(row(OP_STORE, '0, '0, VMAX), mk(STAT_STORED, '0, '0, '0))};
    plan = {plan, typed_row(row(OP_SELECT, '0, '0, VMAX), mk(STAT_PICKED, 8'hff, VMAX, VMAX))};
    plan = {plan, row(OP_STORE, 10, 3, 0)};
    plan = {plan, row(OP_STORE, 20, 1, 0)};
    plan = {plan, row(OP_STORE, 30, 2, 0)};
    plan = {plan, row(OP_STORE, 40, 0, 0)};
    plan = {plan, row(OP_STORE, 40, 0, 0)};
    plan = {plan, row(OP_STORE, 25, 7, 0)};
    plan = {plan, row(OP_SELECT, 0, 0, 30)};
    plan = {plan, row(OP_SELECT, 0, 0, 55)};
    plan = {plan, row(OP_SELECT, 0, 0, 1)};
    plan = {plan, row(OP_STORE, 5, 9, 0)};
    plan = {plan, row(OP_STORE, 6, 9, 0)};
    plan = {plan, row(OP_SELECT, 0, 0, 11)};
    plan = {plan, typed_row(row(OP_SELECT, 0, 0, VMAX), mk(STAT_BAD, '0, '0, '0))};
    plan = {plan, row(OP_STORE, 100, 200, 0)};
    plan = {plan, row(OP_STORE, 3, 128, 0)};
    plan = {plan, row(OP_STORE, 7, 128, 0)};
    plan = {plan, row(OP_SELECT, 0, 0, 99)};
    plan = {plan, row(OP_SELECT, 0, 0, 12)};

    for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_request(plan[i]);

    // Random part: a store/select mix around a fill burst that reaches a full table.
    for (n = 0; n < 207; n++) begin
      idle_on = !(n >= 120 && n < 170);
      rq = row(OP_STORE, rand_value(), 0, 0);
      rq.own = ($urandom_range(3) == 0) ? OWN_W'($urandom_range(3))
                                        : OWN_W'($urandom_range(255));
      if (n >= 20 && n < 90) rq.op = OP_STORE;
      else rq.op = ($urandom_range(99) < 45) ? OP_SELECT : OP_STORE;
      if (rq.op == OP_SELECT) rq.amt = rand_amount();
      else rq.amt = VAL_W'({$urandom(), $urandom()});
      send_request(rq);
    end
    s_valid <= 1'b0;
    idle_on = 1'b1;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS wallet_coin_selector");
    end else begin
      $display("FAIL wallet_coin_selector");
    end
    $finish;
  end

endmodule
